>>> hw/rtl/gpsr_pkg.sv
package gpsr_pkg;

  localparam int PIN_COUNT_DEF = 64;

  localparam logic [1:0] LVL_LOW     = 2'd0;
  localparam logic [1:0] LVL_HIGH    = 2'd1;
  localparam logic [1:0] LVL_UNKNOWN = 2'd2;

  localparam logic [1:0] MODE_INPUT    = 2'd0;
  localparam logic [1:0] MODE_OUTPUT   = 2'd1;
  localparam logic [1:0] MODE_PULLUP   = 2'd2;
  localparam logic [1:0] MODE_PULLDOWN = 2'd3;

  localparam logic [15:0] TRIG_RESET = 16'd800;
  localparam logic [15:0] NO_SAMPLE  = 16'hFFFF;
  localparam logic [15:0] ADC_FULL   = 16'd4095;
  localparam logic [15:0] SIGN_BIT   = 16'h8000;

  localparam logic [31:0] PRE_HIGH_END = 32'd40;
  localparam logic [31:0] PRE_LOW_END  = 32'd120;
  localparam logic [12:0] PRE_END      = 13'd200;
  localparam logic [12:0] BIT_LOW_US   = 13'd50;
  localparam logic [12:0] BIT_ONE_US   = 13'd70;
  localparam logic [12:0] BIT_ZERO_US  = 13'd27;
  localparam logic [12:0] TRAILER_US   = 13'd50;
  localparam logic [5:0]  BIT_COUNT    = 6'd40;

  typedef enum logic [2:0] {
    REQ_SET_MODE    = 3'd0,
    REQ_WRITE       = 3'd1,
    REQ_READ        = 3'd2,
    REQ_ANALOG      = 3'd3,
    REQ_HOST_LEVEL  = 3'd4,
    REQ_HOST_ADC    = 3'd5,
    REQ_HOST_SENSOR = 3'd6
  } gpsr_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WALK,
    ST_DONE
  } gpsr_state_t;

  typedef struct packed {
    logic [1:0]  level;
    logic [1:0]  mode;
    logic [15:0] sample;
    logic        attached;
    logic [15:0] temp;
    logic [15:0] hum;
    logic        active;
    logic [31:0] low_start;
    logic [31:0] reply_start;
  } pin_entry_t;

  typedef struct packed {
    logic       en;
    pin_entry_t data;
  } mem_wr_t;

  localparam pin_entry_t ENTRY_RESET = '{
    level:       LVL_UNKNOWN,
    mode:        MODE_INPUT,
    sample:      NO_SAMPLE,
    attached:    1'b0,
    temp:        16'd0,
    hum:         16'd0,
    active:      1'b0,
    low_start:   32'd0,
    reply_start: 32'd0
  };

endpackage

>>> hw/rtl/gpsr_req_if.sv
interface gpsr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  pin;
  logic [1:0]  mode;
  logic [15:0] value;
  logic [31:0] now_us;
  logic signed [15:0] temperature;
  logic [15:0] humidity;

  modport source (
    output valid, req_type, pin, mode, value, now_us, temperature, humidity,
    input  ready
  );
  modport sink (
    input  valid, req_type, pin, mode, value, now_us, temperature, humidity,
    output ready
  );
endinterface

>>> hw/rtl/gpsr_rsp_if.sv
interface gpsr_rsp_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [15:0] analog_value;
  logic        level_changed;

  modport source (
    output valid, level, analog_value, level_changed,
    input  ready
  );
  modport sink (
    input  valid, level, analog_value, level_changed,
    output ready
  );
endinterface

>>> hw/rtl/gpsr_cfg_if.sv
interface gpsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

>>> hw/rtl/gpsr_mem.sv
module gpsr_mem
  import gpsr_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEF,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output pin_entry_t       rd_data,
  input  mem_wr_t          wr,
  input  logic [IDX_W-1:0] wr_addr
);

  pin_entry_t mem [PIN_COUNT];
  logic [PIN_COUNT-1:0] valid;
  pin_entry_t rd_raw;
  logic rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // Entries never written since reset read as the reset contents.
  assign rd_data = rd_valid ? rd_raw : ENTRY_RESET;

endmodule

>>> hw/rtl/gpsr_core.sv
module gpsr_core
  import gpsr_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEF,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      trig,
  gpsr_req_if.sink         req,
  gpsr_rsp_if.source       rsp,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  pin_entry_t       rd_data,
  output mem_wr_t          wr,
  output logic [IDX_W-1:0] wr_addr
);

  gpsr_state_t state, state_next;

  gpsr_req_t        q_type;
  logic [1:0]       q_mode;
  logic [15:0]      q_value;
  logic [31:0]      q_now;
  logic [15:0]      q_temp;
  logic [15:0]      q_hum;
  logic             q_pin_ok;
  logic [IDX_W-1:0] q_addr;

  pin_entry_t  upd;
  logic        res_level;
  logic [15:0] res_analog;
  logic        res_chg;

  logic [31:0] e;
  logic [39:0] word;
  logic [12:0] pos;
  logic [5:0]  bit_idx;

  logic        accept;
  logic        pin_ok;
  logic        out_free;

  pin_entry_t  look_upd;
  logic        look_level;
  logic [15:0] look_analog;
  logic        look_chg;
  logic        look_walk;
  logic [31:0] look_e;
  logic [39:0] look_word;
  logic        look_trig;
  logic [15:0] mag;
  logic [9:0]  csum_sum;
  logic [1:0]  new_level;

  logic [12:0] bit_len;
  logic [12:0] pos_len;
  logic [12:0] pos_tail;
  logic        walk_done;

  assign accept   = req.valid && req.ready;
  assign pin_ok   = 32'(req.pin) < PIN_COUNT;
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_LOOK;
      ST_LOOK: state_next = look_walk ? ST_WALK : ST_DONE;
      ST_WALK: if (walk_done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    rd_en     = accept;
    rd_addr   = pin_ok ? IDX_W'(req.pin) : '0;
    wr.en     = (state == ST_DONE) && out_free && q_pin_ok;
    wr.data   = upd;
    wr_addr   = q_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    look_e    = q_now - rd_data.reply_start;
    look_trig = (q_now - rd_data.low_start) > {16'd0, trig};
    mag       = rd_data.temp[15] ? ((16'd0 - rd_data.temp) | SIGN_BIT) : rd_data.temp;
    csum_sum  = 10'(rd_data.hum[15:8]) + 10'(rd_data.hum[7:0])
              + 10'(mag[15:8]) + 10'(mag[7:0]);
    look_word = {rd_data.hum, mag, csum_sum[7:0]};
    new_level = (q_value != 16'd0) ? LVL_HIGH : LVL_LOW;

    look_upd    = rd_data;
    look_level  = 1'b0;
    look_analog = 16'd0;
    look_chg    = 1'b0;
    look_walk   = 1'b0;

    case (q_type)
      REQ_SET_MODE: begin
        if (rd_data.attached && (q_mode == MODE_INPUT || q_mode == MODE_PULLUP) &&
            rd_data.mode == MODE_OUTPUT && rd_data.level == LVL_LOW && look_trig) begin
          look_upd.reply_start = q_now;
          look_upd.active      = 1'b1;
        end
        look_upd.mode = q_mode;
        if (q_mode == MODE_PULLUP && rd_data.level == LVL_UNKNOWN) begin
          look_upd.level = LVL_HIGH;
        end else if (q_mode == MODE_PULLDOWN && rd_data.level == LVL_UNKNOWN) begin
          look_upd.level = LVL_LOW;
        end
      end
      REQ_WRITE: begin
        if (rd_data.attached) begin
          if (q_value == 16'd0) begin
            if (rd_data.level != LVL_LOW) begin
              look_upd.low_start = q_now;
            end
          end else if (rd_data.level == LVL_LOW && look_trig) begin
            look_upd.reply_start = q_now;
            look_upd.active      = 1'b1;
          end
        end
        if (rd_data.level != new_level) begin
          look_upd.level = new_level;
          look_chg       = 1'b1;
        end
      end
      REQ_READ: begin
        if (rd_data.attached) begin
          if (!rd_data.active) begin
            look_level = 1'b1;
          end else if (look_e < PRE_HIGH_END) begin
            look_level = 1'b1;
          end else if (look_e < PRE_LOW_END) begin
            look_level = 1'b0;
          end else if (look_e < 32'(PRE_END)) begin
            look_level = 1'b1;
          end else begin
            look_walk = 1'b1;
          end
        end else if (rd_data.level == LVL_UNKNOWN) begin
          look_level = (rd_data.mode == MODE_PULLUP);
        end else begin
          look_level = rd_data.level[0];
        end
      end
      REQ_ANALOG: begin
        if (rd_data.sample == NO_SAMPLE) begin
          look_analog = (rd_data.level == LVL_HIGH) ? ADC_FULL : 16'd0;
        end else begin
          look_analog = rd_data.sample;
        end
      end
      REQ_HOST_LEVEL: begin
        look_upd.level  = new_level;
        look_upd.sample = q_value;
      end
      REQ_HOST_ADC: begin
        look_upd.sample = {4'd0, q_value[11:0]};
      end
      REQ_HOST_SENSOR: begin
        look_upd.attached = 1'b1;
        look_upd.temp     = q_temp;
        look_upd.hum      = q_hum;
      end
      default: begin
      end
    endcase

    if (!q_pin_ok) begin
      look_level  = 1'b0;
      look_analog = 16'd0;
      look_chg    = 1'b0;
      look_walk   = 1'b0;
    end
  end

  always_comb begin
    bit_len   = BIT_LOW_US + (word[39] ? BIT_ONE_US : BIT_ZERO_US);
    pos_len   = pos + bit_len;
    pos_tail  = pos + TRAILER_US;
    walk_done = (bit_idx == BIT_COUNT) || (e < 32'(pos_len));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_type   <= gpsr_req_t'(req.req_type);
      q_mode   <= req.mode;
      q_value  <= req.value;
      q_now    <= req.now_us;
      q_temp   <= req.temperature;
      q_hum    <= req.humidity;
      q_pin_ok <= pin_ok;
      q_addr   <= rd_addr;
    end
    if (state == ST_LOOK) begin
      upd        <= look_upd;
      res_level  <= look_level;
      res_analog <= look_analog;
      res_chg    <= look_chg;
      e          <= look_e;
      word       <= look_word;
      pos        <= PRE_END;
      bit_idx    <= 6'd0;
    end
    if (state == ST_WALK) begin
      if (bit_idx == BIT_COUNT) begin
        res_level <= (e >= 32'(pos_tail));
        if (e >= 32'(pos_tail)) begin
          upd.active <= 1'b0;
        end
      end else if (e < 32'(pos_len)) begin
        res_level <= ((e - 32'(pos)) >= 32'(BIT_LOW_US));
      end else begin
        pos     <= pos_len;
        word    <= {word[38:0], 1'b0};
        bit_idx <= bit_idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsp.level         <= res_level;
      rsp.analog_value  <= res_analog;
      rsp.level_changed <= res_chg;
    end
  end

endmodule

>>> hw/rtl/gpio_pin_with_humidity_sensor_reply_top.sv
// Per-pin GPIO model with an emulated single-wire temperature and humidity sensor.
// Requests are handled one at a time: a request is accepted, its pin entry is
// read from the pin state memory, and the updated entry is written back with the
// result before the next request is accepted. A read of a pin whose sensor reply
// has passed its preamble walks the 40 data bit slots one per cycle to find the
// current one. All pin state lives in one memory with a valid bit per entry,
// which reset clears, so the block accepts requests right after reset. The trigger
// threshold register may be written at any time the block is idle.
module gpio_pin_with_humidity_sensor_reply_top
  import gpsr_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gpsr_req_if.sink   req,
  gpsr_rsp_if.source rsp,
  gpsr_cfg_if.sink   cfg
);

  localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  logic [15:0]      trig;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  pin_entry_t       rd_data;
  mem_wr_t          wr;
  logic [IDX_W-1:0] wr_addr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig <= TRIG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      trig <= cfg.data;
    end
  end

  gpsr_mem #(
    .PIN_COUNT(PIN_COUNT),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr     (wr),
    .wr_addr(wr_addr)
  );

  gpsr_core #(
    .PIN_COUNT(PIN_COUNT),
    .IDX_W    (IDX_W)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .trig   (trig),
    .req    (req),
    .rsp    (rsp),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr     (wr),
    .wr_addr(wr_addr)
  );

`ifndef ASSERT_OFF
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !(req.valid && req.ready))
    else $error("pin memory written while a request is accepted");

  a_wr_after_read: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !$past(rd_en))
    else $error("pin memory written right after its read was issued");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request accepted while one is in flight");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gpsr_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 385;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         pin;
    logic [1:0]         mode;
    logic [15:0]        value;
    logic [31:0]        now_us;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
  } pin_req_t;

  typedef struct packed {
    logic        level;
    logic [15:0] analog_value;
    logic        level_changed;
  } pin_rsp_t;

  class pin_reply_checker;
    logic [1:0]  pin_lvl     [PIN_COUNT_DEF];
    logic [1:0]  pin_md      [PIN_COUNT_DEF];
    logic [15:0] pin_smp     [PIN_COUNT_DEF];
    bit          has_sensor  [PIN_COUNT_DEF];
    logic [15:0] sens_temp   [PIN_COUNT_DEF];
    logic [15:0] sens_hum    [PIN_COUNT_DEF];
    bit          replying    [PIN_COUNT_DEF];
    logic [31:0] low_since   [PIN_COUNT_DEF];
    logic [31:0] reply_since [PIN_COUNT_DEF];
    logic [15:0] trigger_us;
    pin_rsp_t    pending_replies[$];
    int          errors;
    int          checked;

    function new();
      for (int p = 0; p < PIN_COUNT_DEF; p++) begin
        pin_lvl[p] = LVL_UNKNOWN;
        pin_md[p] = MODE_INPUT;
        pin_smp[p] = NO_SAMPLE;
        has_sensor[p] = 1'b0;
        sens_temp[p] = '0;
        sens_hum[p] = '0;
        replying[p] = 1'b0;
        low_since[p] = '0;
        reply_since[p] = '0;
      end
      trigger_us = TRIG_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void set_trigger(logic [15:0] v);
      trigger_us = v;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function bit failed();
      return errors != 0 || pending_replies.size() != 0;
    endfunction

    function void try_start_reply(int p, logic [31:0] now);
      logic [31:0] held;
      held = now - low_since[p];
      if (held > {16'd0, trigger_us}) begin
        reply_since[p] = now;
        replying[p] = 1'b1;
      end
    endfunction

    // Walks the preamble and the 40 bit slots to find the line level at this time.
    function logic reply_level(int p, logic [31:0] now);
      logic [31:0] el;
      logic [31:0] pos;
      logic [31:0] len;
      logic [15:0] t;
      logic [15:0] h;
      logic [15:0] mag;
      logic [7:0]  csum;
      logic [39:0] word;
      el = now - reply_since[p];
      if (el < 32'd40) return 1'b1;
      if (el < 32'd120) return 1'b0;
      if (el < 32'd200) return 1'b1;
      t = sens_temp[p];
      h = sens_hum[p];
      if (t[15]) mag = (~t + 16'd1) | 16'h8000;
      else mag = t;
      csum = h[15:8] + h[7:0] + mag[15:8] + mag[7:0];
      word = {h, mag, csum};
      pos = 32'd200;
      for (int i = 0; i < 40; i++) begin
        len = word[39 - i] ? 32'd120 : 32'd77;
        if (el < pos + len) return (el - pos < 32'd50) ? 1'b0 : 1'b1;
        pos = pos + len;
      end
      if (el < pos + 32'd50) return 1'b0;
      replying[p] = 1'b0;
      return 1'b1;
    endfunction

    function void note_request(pin_req_t r);
      pin_rsp_t want;
      int p;
      logic [1:0] nl;
      want = '0;
      p = r.pin;
      case (r.kind)
        REQ_SET_MODE: begin
          if (has_sensor[p] && (r.mode == MODE_INPUT || r.mode == MODE_PULLUP) &&
              pin_md[p] == MODE_OUTPUT && pin_lvl[p] == LVL_LOW)
            try_start_reply(p, r.now_us);
          pin_md[p] = r.mode;
          if (r.mode == MODE_PULLUP && pin_lvl[p] == LVL_UNKNOWN) pin_lvl[p] = LVL_HIGH;
          else if (r.mode == MODE_PULLDOWN && pin_lvl[p] == LVL_UNKNOWN) pin_lvl[p] = LVL_LOW;
        end
        REQ_WRITE: begin
          nl = (r.value != 16'd0) ? LVL_HIGH : LVL_LOW;
          if (has_sensor[p]) begin
            if (r.value == 16'd0) begin
              if (pin_lvl[p] != LVL_LOW) low_since[p] = r.now_us;
            end else if (pin_lvl[p] == LVL_LOW) begin
              try_start_reply(p, r.now_us);
            end
          end
          if (pin_lvl[p] != nl) begin
            pin_lvl[p] = nl;
            want.level_changed = 1'b1;
          end
        end
        REQ_READ: begin
          if (has_sensor[p]) want.level = replying[p] ? reply_level(p, r.now_us) : 1'b1;
          else if (pin_lvl[p] == LVL_UNKNOWN) want.level = (pin_md[p] == MODE_PULLUP);
          else want.level = pin_lvl[p][0];
        end
        REQ_ANALOG: begin
          if (pin_smp[p] == NO_SAMPLE)
            want.analog_value = (pin_lvl[p] == LVL_HIGH) ? ADC_FULL : 16'd0;
          else
            want.analog_value = pin_smp[p];
        end
        REQ_HOST_LEVEL: begin
          pin_lvl[p] = (r.value != 16'd0) ? LVL_HIGH : LVL_LOW;
          pin_smp[p] = r.value;
        end
        REQ_HOST_ADC: pin_smp[p] = r.value & 16'h0FFF;
        REQ_HOST_SENSOR: begin
          has_sensor[p] = 1'b1;
          sens_temp[p] = r.temperature;
          sens_hum[p] = r.humidity;
        end
        default: ;
      endcase
      pending_replies.push_back(want);
    endfunction

    function void check_result(pin_rsp_t got);
      pin_rsp_t want;
      checked++;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("reply %0d arrived with no request outstanding: level=%b analog=%h changed=%b",
                   checked, got.level, got.analog_value, got.level_changed);
        return;
      end
      want = pending_replies.pop_front();
      if (got.level !== want.level || got.analog_value !== want.analog_value ||
          got.level_changed !== want.level_changed) begin
        errors++;
        if (errors <= 10)
          $display("reply %0d: expected level=%b analog=%h changed=%b, got level=%b analog=%h changed=%b",
                   checked, want.level, want.analog_value, want.level_changed,
                   got.level, got.analog_value, got.level_changed);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  gpsr_req_if req_ch();
  gpsr_rsp_if rsp_ch();
  gpsr_cfg_if cfg_ch();

  gpio_pin_with_humidity_sensor_reply_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  pin_reply_checker board;
  int sent;
  int send_calm;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int next_gap();
    int roll;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      send_calm = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pin_req_t random_req();
    pin_req_t r;
    r.kind = 3'($urandom_range(0, 7));
    r.pin = 6'($urandom_range(0, 63));
    r.mode = 2'($urandom_range(0, 3));
    r.value = 16'($urandom);
    r.now_us = $urandom;
    r.temperature = 16'($urandom);
    r.humidity = 16'($urandom);
    return r;
  endfunction

  function automatic logic [5:0] pick_pin();
    if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 7));
  endfunction

  task automatic issue(input pin_req_t r);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.pin <= r.pin;
    req_ch.mode <= r.mode;
    req_ch.value <= r.value;
    req_ch.now_us <= r.now_us;
    req_ch.temperature <= r.temperature;
    req_ch.humidity <= r.humidity;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(r);
    sent++;
  endtask

  task automatic ask(input logic [2:0] kind, input logic [5:0] pin, input logic [1:0] mode,
                     input logic [15:0] value, input logic [31:0] now,
                     input logic [15:0] temp, input logic [15:0] hum);
    pin_req_t r;
    r = '{kind, pin, mode, value, now, temp, hum};
    issue(r);
  endtask

  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  task automatic write_trigger(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    board.set_trigger(v);
  endtask

  // One host start pulse on a sensor pin followed by reads spread over the reply.
  task automatic sensor_exchange(input logic [5:0] p);
    pin_req_t r;
    logic [31:0] t0;
    logic [31:0] t_end;
    logic [31:0] t_rd;
    int trig;
    int dur;
    int roll;
    int nreads;
    if (!board.has_sensor[p] || $urandom_range(0, 3) != 0) begin
      r = random_req();
      r.kind = REQ_HOST_SENSOR;
      r.pin = p;
      case ($urandom_range(0, 7))
        0: r.temperature = 16'sh8000;
        1: r.temperature = -16'sd32767;
        2: r.temperature = 16'sd32767;
        3: r.temperature = 16'sd0;
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: r.humidity = 16'hFFFF;
        1: r.humidity = 16'h0000;
        default: ;
      endcase
      issue(r);
    end
    r = random_req();
    r.kind = REQ_SET_MODE;
    r.pin = p;
    r.mode = MODE_OUTPUT;
    issue(r);
    t0 = ($urandom_range(0, 7) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom;
    r = random_req();
    r.kind = REQ_WRITE;
    r.pin = p;
    r.value = 16'd0;
    r.now_us = t0;
    issue(r);
    if ($urandom_range(0, 4) == 0) begin
      r.now_us = t0 + $urandom_range(1, 500);
      issue(r);
    end
    if ($urandom_range(0, 7) == 0) begin
      r = random_req();
      r.pin = p;
      issue(r);
    end
    trig = int'(board.trigger_us);
    roll = $urandom_range(0, 9);
    if (roll < 6) dur = trig + 1 + $urandom_range(0, 300);
    else if (roll < 7) dur = trig;
    else if (roll < 8) dur = trig - $urandom_range(0, trig);
    else dur = $urandom_range(0, 200000);
    t_end = t0 + 32'(dur);
    r = random_req();
    r.pin = p;
    r.now_us = t_end;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      r.kind = REQ_WRITE;
      r.value = 16'($urandom_range(1, 65535));
    end else begin
      r.kind = REQ_SET_MODE;
      if (roll < 6) r.mode = MODE_INPUT;
      else if (roll < 8) r.mode = MODE_PULLUP;
      else if (roll < 9) r.mode = MODE_PULLDOWN;
      else r.mode = MODE_OUTPUT;
    end
    issue(r);
    nreads = $urandom_range(4, 14);
    t_rd = t_end;
    for (int i = 0; i < nreads; i++) begin
      if ($urandom_range(0, 7) == 0) t_rd = t_rd + $urandom_range(2000, 7000);
      else t_rd = t_rd + $urandom_range(0, 800);
      r = random_req();
      r.pin = p;
      r.now_us = t_rd;
      r.kind = ($urandom_range(0, 9) == 0) ? REQ_ANALOG : REQ_READ;
      issue(r);
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : reply_sink
    int stall;
    int calm;
    int roll;
    pin_rsp_t got;
    stall = 0;
    calm = 0;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got = {rsp_ch.level, rsp_ch.analog_value, rsp_ch.level_changed};
        board.check_result(got);
        if (board.checked == 150 || board.checked == 1100) stall = 600;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (calm > 0) begin
        calm--;
        rsp_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) calm = $urandom_range(50, 250);
        if (roll < 70) begin
          rsp_ch.ready <= 1'b1;
        end else begin
          rsp_ch.ready <= 1'b0;
          if (roll < 92) stall = $urandom_range(0, 2);
          else if (roll < 98) stall = $urandom_range(3, 11);
          else stall = $urandom_range(19, 59);
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] trig_plan [5];
    pin_req_t r;
    int phase_start;
    bit paused;
    board = new();
    sent = 0;
    send_calm = 0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.pin = '0;
    req_ch.mode = '0;
    req_ch.value = '0;
    req_ch.now_us = '0;
    req_ch.temperature = '0;
    req_ch.humidity = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    ask(REQ_READ, 6'd0, MODE_INPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_ANALOG, 6'd0, MODE_INPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_SET_MODE, 6'd1, MODE_PULLUP, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_READ, 6'd1, MODE_INPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_SET_MODE, 6'd2, MODE_PULLDOWN, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_READ, 6'd2, MODE_INPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_UNUSED, 6'd63, MODE_PULLDOWN, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    ask(REQ_HOST_LEVEL, 6'd63, MODE_INPUT, 16'hFFFF, 32'd0, 16'd0, 16'd0);
    ask(REQ_ANALOG, 6'd63, MODE_INPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_HOST_ADC, 6'd3, MODE_INPUT, 16'hFFFF, 32'd0, 16'd0, 16'd0);
    ask(REQ_ANALOG, 6'd3, MODE_INPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_WRITE, 6'd4, MODE_INPUT, 16'd0, 32'd100, 16'd0, 16'd0);
    ask(REQ_WRITE, 6'd4, MODE_INPUT, 16'd0, 32'd200, 16'd0, 16'd0);
    ask(REQ_WRITE, 6'd4, MODE_INPUT, 16'd1, 32'd300, 16'd0, 16'd0);
    ask(REQ_HOST_SENSOR, 6'd5, MODE_INPUT, 16'd0, 32'd0, 16'h8000, 16'hFFFF);
    ask(REQ_SET_MODE, 6'd5, MODE_OUTPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_WRITE, 6'd5, MODE_INPUT, 16'd0, 32'd1000, 16'd0, 16'd0);
    ask(REQ_WRITE, 6'd5, MODE_INPUT, 16'd1, 32'd1801, 16'd0, 16'd0);
    ask(REQ_READ, 6'd5, MODE_INPUT, 16'd0, 32'd1931, 16'd0, 16'd0);
    ask(REQ_READ, 6'd5, MODE_INPUT, 16'd0, 32'd2061, 16'd0, 16'd0);
    ask(REQ_READ, 6'd5, MODE_INPUT, 16'd0, 32'd10801, 16'd0, 16'd0);
    ask(REQ_HOST_SENSOR, 6'd6, MODE_INPUT, 16'd0, 32'd0, 16'h7FFF, 16'h0000);
    ask(REQ_SET_MODE, 6'd6, MODE_OUTPUT, 16'd0, 32'd0, 16'd0, 16'd0);
    ask(REQ_WRITE, 6'd6, MODE_INPUT, 16'd0, 32'hFFFF_FF00, 16'd0, 16'd0);
    ask(REQ_SET_MODE, 6'd6, MODE_INPUT, 16'd0, 32'h0000_0300, 16'd0, 16'd0);
    ask(REQ_READ, 6'd6, MODE_INPUT, 16'd0, 32'h0000_033C, 16'd0, 16'd0);

    trig_plan = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd1, TRIG_RESET};
    for (int k = 0; k < 5; k++) begin
      drain_replies();
      write_trigger(trig_plan[k]);
      phase_start = sent;
      paused = 1'b0;
      while (sent - phase_start < PHASE_ITEMS) begin
        if (!paused && sent - phase_start >= PHASE_ITEMS / 2) begin
          drain_replies();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 6) begin
          sensor_exchange(pick_pin());
        end else begin
          repeat ($urandom_range(1, 6)) begin
            r = random_req();
            r.pin = pick_pin();
            if ($urandom_range(0, 3) == 0) r.value = 16'd0;
            issue(r);
          end
        end
      end
    end

    drain_replies();
    repeat (100) @(posedge clk);
    if (board.failed()) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end
endmodule
